### src/mfap_pkg.sv
// Shared types and constants for the max-flow augmenting path core.
// Used by the controller, the datapath and the top level; depends on nothing.
package mfap_pkg;

    // Graph and word sizes.
    localparam int unsigned MAX_NODES = 16;
    localparam int unsigned NODE_W    = 4;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned CAP_BITS  = 16;
    localparam int unsigned RES_W     = CAP_BITS + 1;
    localparam int unsigned FLOW_W    = 20;
    localparam int unsigned ADDR_W    = 2 * NODE_W;
    localparam int unsigned MEM_DEPTH = MAX_NODES * MAX_NODES;

    // Configuration register indexes.
    localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [1:0] REG_SOURCE_NODE = 2'd1;
    localparam logic [1:0] REG_SINK_NODE   = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_BFS_START,
        ST_BFS_POP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_WALK_INIT,
        ST_WALK_RD,
        ST_WALK_MIN,
        ST_UPD_INIT,
        ST_UPD_RD,
        ST_UPD_FWD,
        ST_UPD_REV,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_entry;
        logic clr_flow;
        logic bfs_init;
        logic bfs_pop;
        logic scan_read;
        logic scan_skip;
        logic scan_check;
        logic walk_init;
        logic walk_read;
        logic walk_min;
        logic upd_init;
        logic upd_read;
        logic upd_fwd;
        logic upd_rev;
        logic add_flow;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_cfg;
        logic q_empty;
        logic v_end;
        logic v_seen;
        logic edge_pos;
        logic v_is_dst;
        logic walk_end;
    } t_status;

    // Node count limited to the range the search supports.
    function automatic logic [CNT_W-1:0] clamp_nodes(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        res = cnt;
        if (cnt < CNT_W'(2)) begin
            res = CNT_W'(2);
        end else if (cnt > CNT_W'(MAX_NODES)) begin
            res = CNT_W'(MAX_NODES);
        end
        return res;
    endfunction

endpackage

### src/mfap_ctrl.sv
// Sequencing state machine of the max-flow core.
// Depends on mfap_pkg; drives the datapath through a command struct.
module mfap_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last_entry,
    input  mfap_pkg::t_status i_status,
    output mfap_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import mfap_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.ld_entry = 1'b1;
                    if (i_last_entry) begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.clr_flow = 1'b1;
                n_state = i_status.bad_cfg ? ST_DONE : ST_BFS_START;
            end
            ST_BFS_START: begin
                o_cmd.bfs_init = 1'b1;
                n_state = ST_BFS_POP;
            end
            ST_BFS_POP: begin
                if (i_status.q_empty) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.bfs_pop = 1'b1;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (i_status.v_end) begin
                    n_state = ST_BFS_POP;
                end else if (i_status.v_seen) begin
                    o_cmd.scan_skip = 1'b1;
                end else begin
                    o_cmd.scan_read = 1'b1;
                    n_state = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                o_cmd.scan_check = 1'b1;
                if (i_status.edge_pos && i_status.v_is_dst) begin
                    n_state = ST_WALK_INIT;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_WALK_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state = ST_WALK_RD;
            end
            ST_WALK_RD: begin
                if (i_status.walk_end) begin
                    n_state = ST_UPD_INIT;
                end else begin
                    o_cmd.walk_read = 1'b1;
                    n_state = ST_WALK_MIN;
                end
            end
            ST_WALK_MIN: begin
                o_cmd.walk_min = 1'b1;
                n_state = ST_WALK_RD;
            end
            ST_UPD_INIT: begin
                o_cmd.upd_init = 1'b1;
                n_state = ST_UPD_RD;
            end
            ST_UPD_RD: begin
                if (i_status.walk_end) begin
                    o_cmd.add_flow = 1'b1;
                    n_state = ST_BFS_START;
                end else begin
                    o_cmd.upd_read = 1'b1;
                    n_state = ST_UPD_FWD;
                end
            end
            ST_UPD_FWD: begin
                o_cmd.upd_fwd = 1'b1;
                n_state = ST_UPD_REV;
            end
            ST_UPD_REV: begin
                o_cmd.upd_rev = 1'b1;
                n_state = ST_UPD_RD;
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

### src/mfap_datapath.sv
// Residual memory, search queue, parent links and flow arithmetic.
// Depends on mfap_pkg; acts on commands from mfap_ctrl.
module mfap_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mfap_pkg::t_cmd                 i_cmd,
    output mfap_pkg::t_status              o_status,
    input  logic [mfap_pkg::CNT_W-1:0]     i_node_count,
    input  logic [mfap_pkg::NODE_W-1:0]    i_source_node,
    input  logic [mfap_pkg::NODE_W-1:0]    i_sink_node,
    input  logic [mfap_pkg::NODE_W-1:0]    i_from_node,
    input  logic [mfap_pkg::NODE_W-1:0]    i_to_node,
    input  logic [mfap_pkg::CAP_BITS-1:0]  i_capacity,
    output logic [mfap_pkg::FLOW_W-1:0]    o_max_flow,
    output logic                           o_result_valid
);
    import mfap_pkg::*;

    // Residual memory with a valid bit per entry; invalid entries read as zero.
    logic [RES_W-1:0]     r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mem_vld;
    logic [RES_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    logic [NODE_W-1:0] r_queue  [MAX_NODES];
    logic [NODE_W-1:0] r_parent [MAX_NODES];
    logic [MAX_NODES-1:0] r_visited;
    logic [NODE_W-1:0] r_cur;
    logic [CNT_W-1:0]  r_v;
    logic [CNT_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_tail;
    logic [NODE_W-1:0] r_node;
    logic [CNT_W-1:0]  r_steps;
    logic [RES_W-1:0]  r_bn;
    logic [FLOW_W-1:0] r_flow;
    logic [FLOW_W-1:0] r_max_flow;
    logic              r_result_valid;

    logic [CNT_W-1:0]  n_nodes;
    logic [RES_W-1:0]  rd_word;
    logic [NODE_W-1:0] par;
    logic [NODE_W-1:0] v_idx;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [RES_W-1:0]  wdata;

    assign n_nodes = clamp_nodes(i_node_count);
    assign rd_word = r_rd_vld ? r_rd_data : '0;
    assign par     = r_parent[r_node];
    assign v_idx   = r_v[NODE_W-1:0];

    // Memory address and data selection.
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        waddr  = {par, r_node};
        raddr  = {par, r_node};
        wdata  = '0;
        if (i_cmd.ld_entry) begin
            mem_we = 1'b1;
            waddr  = {i_from_node, i_to_node};
            wdata  = RES_W'(i_capacity);
        end
        if (i_cmd.scan_read) begin
            mem_re = 1'b1;
            raddr  = {r_cur, v_idx};
        end
        if (i_cmd.walk_read || i_cmd.upd_read) begin
            mem_re = 1'b1;
        end
        if (i_cmd.upd_fwd) begin
            mem_we = 1'b1;
            wdata  = rd_word - r_bn;
            mem_re = 1'b1;
            raddr  = {r_node, par};
        end
        if (i_cmd.upd_rev) begin
            mem_we = 1'b1;
            waddr  = {r_node, par};
            wdata  = rd_word + r_bn;
        end
    end

    // Memory array.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    // Valid bits and registered valid of the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_mem_vld[waddr] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vld <= r_mem_vld[raddr];
            end
        end
    end

    // Breadth-first search state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.bfs_init) begin
            r_visited <= MAX_NODES'(1) << i_source_node;
            r_queue[0] <= i_source_node;
            r_head <= '0;
            r_tail <= CNT_W'(1);
        end
        if (i_cmd.bfs_pop) begin
            r_cur  <= r_queue[r_head[NODE_W-1:0]];
            r_head <= r_head + CNT_W'(1);
            r_v    <= '0;
        end
        if (i_cmd.scan_skip) begin
            r_v <= r_v + CNT_W'(1);
        end
        if (i_cmd.scan_check) begin
            r_v <= r_v + CNT_W'(1);
            if (rd_word != '0) begin
                r_parent[v_idx] <= r_cur;
                if (v_idx != i_sink_node) begin
                    r_visited[v_idx] <= 1'b1;
                    if (r_tail < CNT_W'(MAX_NODES)) begin
                        r_queue[r_tail[NODE_W-1:0]] <= v_idx;
                        r_tail <= r_tail + CNT_W'(1);
                    end
                end
            end
        end
    end

    // Path walks: bottleneck search, then residual update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init || i_cmd.upd_init) begin
            r_node  <= i_sink_node;
            r_steps <= '0;
        end
        if (i_cmd.walk_init) begin
            r_bn <= '1;
        end
        if (i_cmd.walk_min) begin
            if (rd_word < r_bn) begin
                r_bn <= rd_word;
            end
            r_node  <= par;
            r_steps <= r_steps + CNT_W'(1);
        end
        if (i_cmd.upd_rev) begin
            r_node  <= par;
            r_steps <= r_steps + CNT_W'(1);
        end
    end

    // Flow total and result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow         <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.finish;
            if (i_cmd.clr_flow) begin
                r_flow <= '0;
            end else if (i_cmd.add_flow) begin
                r_flow <= r_flow + FLOW_W'(r_bn);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_max_flow <= r_flow;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.bad_cfg  = ({1'b0, i_source_node} >= n_nodes) ||
                            ({1'b0, i_sink_node} >= n_nodes) ||
                            (i_source_node == i_sink_node);
        o_status.q_empty  = (r_head == r_tail);
        o_status.v_end    = (r_v >= n_nodes);
        o_status.v_seen   = r_visited[v_idx];
        o_status.edge_pos = (rd_word != '0);
        o_status.v_is_dst = (v_idx == i_sink_node);
        o_status.walk_end = (r_node == i_source_node) || (r_steps >= n_nodes);
    end

    assign o_max_flow     = r_max_flow;
    assign o_result_valid = r_result_valid;

endmodule

### src/max_flow_augmenting_path_core.sv
// Top level of the max-flow core: configuration registers, controller, datapath.
// Depends on mfap_pkg, mfap_ctrl and mfap_datapath.
//
// Capacity entries load one word per cycle while busy is low. The word with
// last_entry set is stored and starts the computation: busy then stays high
// while repeated breadth-first searches run over the 16x16 residual memory.
// Each search reads and then checks the residual of every unvisited candidate
// neighbor, and skips a visited one without a read. Each augmentation walks the
// path twice: once to find the bottleneck and once to update both residuals.
// The memory has one read and one write port, and that port sets the pace.
// The result appears on o_max_flow with o_result_valid high for one cycle; the
// receiver cannot stall it. The matrix is cleared through its valid bits at
// reset and with each result.
module max_flow_augmenting_path_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mfap_pkg::NODE_W-1:0]   i_from_node,
    input  logic [mfap_pkg::NODE_W-1:0]   i_to_node,
    input  logic [mfap_pkg::CAP_BITS-1:0] i_capacity,
    input  logic                          i_last_entry,
    output logic [mfap_pkg::FLOW_W-1:0]   o_max_flow,
    output logic                          o_result_valid,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mfap_pkg::*;

    logic [CNT_W-1:0]  r_node_count;
    logic [NODE_W-1:0] r_source_node;
    logic [NODE_W-1:0] r_sink_node;
    logic              cfg_wr;
    t_cmd              cmd;
    t_status           status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= CNT_W'(MAX_NODES);
            r_source_node <= '0;
            r_sink_node   <= NODE_W'(MAX_NODES - 1);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_NODE_COUNT:  r_node_count  <= pwdata[CNT_W-1:0];
                REG_SOURCE_NODE: r_source_node <= pwdata[NODE_W-1:0];
                REG_SINK_NODE:   r_sink_node   <= pwdata[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        unique case (paddr[3:2])
            REG_NODE_COUNT:  prdata = 32'(r_node_count);
            REG_SOURCE_NODE: prdata = 32'(r_source_node);
            REG_SINK_NODE:   prdata = 32'(r_sink_node);
            default:         prdata = '0;
        endcase
    end

    mfap_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_last_entry (i_last_entry),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_busy       (busy)
    );

    mfap_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_node_count   (r_node_count),
        .i_source_node  (r_source_node),
        .i_sink_node    (r_sink_node),
        .i_from_node    (i_from_node),
        .i_to_node      (i_to_node),
        .i_capacity     (i_capacity),
        .o_max_flow     (o_max_flow),
        .o_result_valid (o_result_valid)
    );

endmodule

### src/mfap_checker.sv
// Port-level checks on the max-flow core, and their bind to the top level.
// Depends only on the ports of max_flow_augmenting_path_core.
module mfap_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_entry,
    input logic o_result_valid
);

    // A result word is only shown at the end of a run.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result word outside a run");

    // After a result the core is ready for the next graph.
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("core still busy after result");

    // An ordinary entry never starts a run.
    a_plain_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_entry) |=> (!busy && !o_result_valid))
        else $error("ordinary entry started a run");

    // The final entry always starts a run.
    a_last_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_entry) |=> busy)
        else $error("final entry did not start a run");

endmodule

bind max_flow_augmenting_path_core mfap_checker u_mfap_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last_entry   (i_last_entry),
    .o_result_valid (o_result_valid)
);

### sim/max_flow_augmenting_path_core_test.sv
// Self-checking testbench for the max-flow augmenting path core.
// Depends on mfap_pkg and max_flow_augmenting_path_core; loads graphs and checks each flow.
module max_flow_augmenting_path_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mfap_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [NODE_W-1:0]   i_from_node;
    logic [NODE_W-1:0]   i_to_node;
    logic [CAP_BITS-1:0] i_capacity;
    logic                i_last_entry;
    logic [FLOW_W-1:0]   o_max_flow;
    logic                o_result_valid;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    max_flow_augmenting_path_core i_dut (.*);

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Predictor state: residual capacities and configuration.
    logic [RES_W-1:0]  res_cap [MAX_NODES][MAX_NODES];
    logic [CNT_W-1:0]  cfg_nodes;
    logic [NODE_W-1:0] cfg_src;
    logic [NODE_W-1:0] cfg_dst;
    logic [FLOW_W-1:0] flow_due [$];
    int                mismatches;
    int                failed;
    int                idle_cycles;

    typedef struct {
        logic [NODE_W-1:0]   from_n;
        logic [NODE_W-1:0]   to_n;
        logic [CAP_BITS-1:0] cap;
        logic                last;
        int                  known;
    } t_entry;

    // Breadth-first search over the residual matrix; fills parent links.
    function automatic bit find_route(input int n, input int s, input int d,
                                      ref int par[MAX_NODES]);
        int q[MAX_NODES];
        int head;
        int tail;
        int cur;
        bit seen[MAX_NODES];
        head = 0;
        tail = 0;
        foreach (seen[k]) seen[k] = 1'b0;
        seen[s] = 1'b1;
        q[tail++] = s;
        while (head < tail) begin
            cur = q[head++];
            for (int v = 0; v < n; v++) begin
                if (!seen[v] && res_cap[cur][v] > 0) begin
                    par[v] = cur;
                    if (v == d) return 1'b1;
                    seen[v] = 1'b1;
                    if (tail < MAX_NODES) q[tail++] = v;
                end
            end
        end
        return 1'b0;
    endfunction

    // Edmonds-Karp over the stored graph, then clear it.
    function automatic logic [FLOW_W-1:0] solve_flow();
        int n;
        int s;
        int d;
        int node;
        int p;
        int steps;
        int par[MAX_NODES];
        logic [31:0] neck;
        logic [FLOW_W-1:0] total;
        n = cfg_nodes;
        if (n < 2) n = 2;
        if (n > MAX_NODES) n = MAX_NODES;
        s = cfg_src;
        d = cfg_dst;
        total = '0;
        if (!(s >= n || d >= n || s == d)) begin
            while (find_route(n, s, d, par)) begin
                neck = 32'hFFFF_FFFF;
                node = d;
                steps = 0;
                while (node != s && steps < n) begin
                    p = par[node];
                    if (res_cap[p][node] < neck) neck = 32'(res_cap[p][node]);
                    node = p;
                    steps++;
                end
                node = d;
                steps = 0;
                while (node != s && steps < n) begin
                    p = par[node];
                    res_cap[p][node] = res_cap[p][node] - neck[RES_W-1:0];
                    res_cap[node][p] = res_cap[node][p] + neck[RES_W-1:0];
                    node = p;
                    steps++;
                end
                total = total + neck[FLOW_W-1:0];
            end
        end
        foreach (res_cap[a, b]) res_cap[a][b] = '0;
        return total;
    endfunction

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_result_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 10000000) begin
                $display("FAIL max_flow_augmenting_path_core");
                $finish;
            end
            if (o_result_valid) begin
                if (flow_due.size() == 0) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: max_flow=%0d", o_max_flow);
                end else begin
                    if (o_max_flow !== flow_due[0]) begin
                        failed = 1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("max_flow mismatch: expected %0d, got %0d",
                                     flow_due[0], o_max_flow);
                    end
                    void'(flow_due.pop_front());
                end
            end
        end
    end

    // APB register write with setup and access phases.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NODE_COUNT:  cfg_nodes = val[CNT_W-1:0];
            REG_SOURCE_NODE: cfg_src = val[NODE_W-1:0];
            REG_SINK_NODE:   cfg_dst = val[NODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_graph_cfg(input int n, input int s, input int d);
        write_reg(REG_NODE_COUNT, 32'(n));
        write_reg(REG_SOURCE_NODE, 32'(s));
        write_reg(REG_SINK_NODE, 32'(d));
    endtask

    // Drop start, wait for every expected word, then let the core settle.
    task automatic drain();
        start <= 1'b0;
        while (flow_due.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Present one capacity word and hold it until accepted.
    task automatic send_word(input t_entry e);
        logic [FLOW_W-1:0] want;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_from_node  <= e.from_n;
        i_to_node    <= e.to_n;
        i_capacity   <= e.cap;
        i_last_entry <= e.last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        res_cap[e.from_n][e.to_n] = {1'b0, e.cap};
        if (e.last) begin
            want = solve_flow();
            if (e.known >= 0 && want !== e.known[FLOW_W-1:0]) begin
                failed = 1;
                $display("directed row disagrees: typed %0d, predicted %0d", e.known, want);
            end
            flow_due.push_back(want);
        end
    endtask

    function automatic t_entry mk(input int f, input int t, input int c, input int l,
                                  input int k);
        t_entry e;
        e.from_n = NODE_W'(f);
        e.to_n = NODE_W'(t);
        e.cap = CAP_BITS'(c);
        e.last = l[0];
        e.known = k;
        return e;
    endfunction

    t_entry directed [$];
    t_entry e;
    int n_nodes;
    int src;
    int dst;
    int count;
    int len;
    int hi;

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_from_node = '0;
        i_to_node = '0;
        i_capacity = '0;
        i_last_entry = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        failed = 0;
        idle_cycles = 0;
        cfg_nodes = 5'd16;
        cfg_src = 4'd0;
        cfg_dst = 4'd15;
        foreach (res_cap[a, b]) res_cap[a][b] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset configuration: empty graph, max edge, paths.
        directed.push_back(mk(0, 15, 0, 1, 0));
        directed.push_back(mk(0, 15, 65535, 1, 65535));
        directed.push_back(mk(0, 15, 5, 0, -1));
        directed.push_back(mk(0, 15, 9, 1, 9));
        directed.push_back(mk(0, 7, 100, 0, -1));
        directed.push_back(mk(7, 15, 40, 1, 40));
        directed.push_back(mk(15, 0, 500, 0, -1));
        directed.push_back(mk(0, 3, 65535, 0, -1));
        directed.push_back(mk(3, 15, 65535, 0, -1));
        directed.push_back(mk(0, 4, 65535, 0, -1));
        directed.push_back(mk(4, 15, 65535, 1, 131070));
        directed.push_back(mk(0, 1, 10, 0, -1));
        directed.push_back(mk(0, 2, 10, 0, -1));
        directed.push_back(mk(1, 2, 5, 0, -1));
        directed.push_back(mk(2, 1, 15, 0, -1));
        directed.push_back(mk(1, 15, 10, 0, -1));
        directed.push_back(mk(2, 15, 10, 1, -1));
        foreach (directed[i]) send_word(directed[i]);
        drain();

        // Source equals sink, and sink beyond node count.
        set_graph_cfg(16, 5, 5);
        send_word(mk(5, 6, 100, 0, -1));
        send_word(mk(6, 5, 100, 1, 0));
        drain();
        set_graph_cfg(4, 0, 9);
        send_word(mk(0, 9, 100, 1, 0));
        drain();
        // Entry outside node count, and node count clamped from below and above.
        set_graph_cfg(3, 0, 2);
        send_word(mk(0, 5, 50, 0, -1));
        send_word(mk(5, 2, 50, 0, -1));
        send_word(mk(0, 2, 7, 1, 7));
        drain();
        set_graph_cfg(0, 0, 1);
        send_word(mk(0, 1, 33, 1, 33));
        drain();
        set_graph_cfg(31, 15, 0);
        send_word(mk(15, 0, 12, 1, 12));
        drain();

        // Random graphs: mostly small, a few full size.
        count = 0;
        while (count < 1030) begin
            n_nodes = ($urandom_range(0, 15) == 0) ? 16 : $urandom_range(2, 6);
            if ($urandom_range(0, 20) == 0) n_nodes = $urandom_range(0, 31);
            src = $urandom_range(0, 15);
            dst = $urandom_range(0, 15);
            if ($urandom_range(0, 5) != 0) begin
                src = $urandom_range(0, (n_nodes > 2 && n_nodes <= 16) ? n_nodes - 1 : 1);
                dst = $urandom_range(0, (n_nodes > 2 && n_nodes <= 16) ? n_nodes - 1 : 1);
            end
            set_graph_cfg(n_nodes, src, dst);
            hi = (n_nodes >= 2 && n_nodes <= 16) ? n_nodes - 1 : 1;
            len = $urandom_range(1, 30);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    e.from_n = NODE_W'($urandom);
                    e.to_n = NODE_W'($urandom);
                end else begin
                    e.from_n = NODE_W'($urandom_range(0, hi));
                    e.to_n = NODE_W'($urandom_range(0, hi));
                end
                case ($urandom_range(0, 3))
                    0: e.cap = CAP_BITS'($urandom);
                    1: e.cap = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: e.cap = CAP_BITS'($urandom_range(1, 64));
                endcase
                e.last = (k == len - 1);
                e.known = -1;
                send_word(e);
                count++;
            end
            // Hold off until the answer is back before reconfiguring.
            drain();
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (failed == 0 && flow_due.size() == 0) begin
            $display("PASS max_flow_augmenting_path_core");
        end else begin
            $display("FAIL max_flow_augmenting_path_core");
        end
        $finish;
    end
endmodule
